// ===== rtl/memory_pressure_level_monitor_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the memory pressure monitor
// every macro samples on clk and is off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef MEMORY_PRESSURE_LEVEL_MONITOR_MACROS_SVH
`define MEMORY_PRESSURE_LEVEL_MONITOR_MACROS_SVH

// condition holds at every clock edge out of reset
`define MPLM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define MPLM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define MPLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mplm_pkg.sv =====
// ---------------------------------------------------------------------------
// mplm_pkg
// types, register map and constants of the memory pressure level monitor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mplm_pkg;

  // width of one byte-count reading
  localparam int BYTE_COUNT_BITS = 24;
  localparam int TIME_W          = 32;
  localparam int PERIOD_W        = 16;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // register map, index = paddr / 4
  typedef enum logic [2:0] {
    REG_WARN   = 3'd0,
    REG_CRIT   = 3'd1,
    REG_EMER   = 3'd2,
    REG_HYST   = 3'd3,
    REG_PERIOD = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [BYTE_COUNT_BITS-1:0] WARN_RESET   = BYTE_COUNT_BITS'(32768);
  localparam logic [BYTE_COUNT_BITS-1:0] CRIT_RESET   = BYTE_COUNT_BITS'(16384);
  localparam logic [BYTE_COUNT_BITS-1:0] EMER_RESET   = BYTE_COUNT_BITS'(8192);
  localparam logic [BYTE_COUNT_BITS-1:0] HYST_RESET   = BYTE_COUNT_BITS'(4096);
  localparam logic [PERIOD_W-1:0]        PERIOD_RESET = PERIOD_W'(1000);

  // pressure levels
  typedef enum logic [1:0] {
    LVL_NORMAL    = 2'd0,
    LVL_WARN      = 2'd1,
    LVL_CRITICAL  = 2'd2,
    LVL_EMERGENCY = 2'd3
  } lvl_t;

  // event codes
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_ESCALATE  = 2'd1,
    EV_STEP_DOWN = 2'd2
  } ev_t;

  // period scale per level
  localparam logic [2:0] SCALE_BASE = 3'd1;
  localparam logic [2:0] SCALE_CRIT = 3'd2;
  localparam logic [2:0] SCALE_EMER = 3'd5;

  // configuration registers
  typedef struct packed {
    logic [BYTE_COUNT_BITS-1:0] warn_threshold;
    logic [BYTE_COUNT_BITS-1:0] critical_threshold;
    logic [BYTE_COUNT_BITS-1:0] emergency_threshold;
    logic [BYTE_COUNT_BITS-1:0] hysteresis_bytes;
    logic [PERIOD_W-1:0]        sample_period_ms;
  } cfg_t;

  // input item
  typedef struct packed {
    logic [TIME_W-1:0]          now_ms;
    logic [BYTE_COUNT_BITS-1:0] free_bytes;
    logic [BYTE_COUNT_BITS-1:0] min_free_bytes;
    logic [BYTE_COUNT_BITS-1:0] largest_block_bytes;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]                 pressure_level;
    logic [2:0]                 scale_factor;
    logic                       sampled;
    logic [1:0]                 event_code;
    logic [BYTE_COUNT_BITS-1:0] stored_free;
    logic [BYTE_COUNT_BITS-1:0] stored_min_free;
    logic [BYTE_COUNT_BITS-1:0] stored_largest;
  } out_item_t;

  // monitor state carried from item to item
  typedef struct packed {
    logic [TIME_W-1:0]          last_time;
    logic                       sampled_before;
    lvl_t                       level;
    logic [BYTE_COUNT_BITS-1:0] held_free;
    logic [BYTE_COUNT_BITS-1:0] held_min_free;
    logic [BYTE_COUNT_BITS-1:0] held_largest;
  } mon_state_t;

endpackage

// ===== rtl/mplm_cfg.sv =====
// ---------------------------------------------------------------------------
// mplm_cfg
// register file behind the configuration bus: thresholds, hysteresis, period
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mplm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mplm_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [mplm_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [mplm_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output mplm_pkg::cfg_t              cfg
);
  import mplm_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  reg_idx_t   idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_WARN:   cfg_nxt.warn_threshold      = cfg_pwdata[BYTE_COUNT_BITS-1:0];
        REG_CRIT:   cfg_nxt.critical_threshold  = cfg_pwdata[BYTE_COUNT_BITS-1:0];
        REG_EMER:   cfg_nxt.emergency_threshold = cfg_pwdata[BYTE_COUNT_BITS-1:0];
        REG_HYST:   cfg_nxt.hysteresis_bytes    = cfg_pwdata[BYTE_COUNT_BITS-1:0];
        REG_PERIOD: cfg_nxt.sample_period_ms    = cfg_pwdata[PERIOD_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn_threshold      <= WARN_RESET;
      cfg_r.critical_threshold  <= CRIT_RESET;
      cfg_r.emergency_threshold <= EMER_RESET;
      cfg_r.hysteresis_bytes    <= HYST_RESET;
      cfg_r.sample_period_ms    <= PERIOD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_WARN:   cfg_prdata = DATA_W'(cfg_r.warn_threshold);
      REG_CRIT:   cfg_prdata = DATA_W'(cfg_r.critical_threshold);
      REG_EMER:   cfg_prdata = DATA_W'(cfg_r.emergency_threshold);
      REG_HYST:   cfg_prdata = DATA_W'(cfg_r.hysteresis_bytes);
      REG_PERIOD: cfg_prdata = DATA_W'(cfg_r.sample_period_ms);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/mplm_eval.sv =====
// ---------------------------------------------------------------------------
// mplm_eval
// per-item decision: sample gate, target level, hysteresis step-down
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mplm_eval (
  input  mplm_pkg::cfg_t       cfg,
  input  mplm_pkg::in_item_t   item,
  input  mplm_pkg::mon_state_t st,
  output mplm_pkg::mon_state_t st_nxt,
  output mplm_pkg::out_item_t  result
);
  import mplm_pkg::*;

  logic [TIME_W-1:0]          diff;
  logic                       too_early;
  logic                       take;
  lvl_t                       tgt;
  logic [BYTE_COUNT_BITS-1:0] entry;
  logic [BYTE_COUNT_BITS:0]   release_lvl;
  logic                       can_step;
  lvl_t                       lvl_new;
  ev_t                        ev;

  // signed wrapping time compare against the sample period
  assign diff      = item.now_ms - st.last_time;
  assign too_early = st.sampled_before &&
                     (diff[TIME_W-1] || (diff < TIME_W'(cfg.sample_period_ms)));
  assign take      = !too_early;

  // target level, most severe threshold first
  always_comb begin
    if (item.free_bytes < cfg.emergency_threshold) begin
      tgt = LVL_EMERGENCY;
    end else if (item.free_bytes < cfg.critical_threshold) begin
      tgt = LVL_CRITICAL;
    end else if (item.free_bytes < cfg.warn_threshold) begin
      tgt = LVL_WARN;
    end else begin
      tgt = LVL_NORMAL;
    end
  end

  // entry threshold of the current level
  always_comb begin
    case (st.level)
      LVL_EMERGENCY: entry = cfg.emergency_threshold;
      LVL_CRITICAL:  entry = cfg.critical_threshold;
      LVL_WARN:      entry = cfg.warn_threshold;
      default:       entry = '0;
    endcase
  end

  // one bit wider so the sum cannot wrap
  assign release_lvl = {1'b0, entry} + {1'b0, cfg.hysteresis_bytes};
  assign can_step    = {1'b0, item.free_bytes} > release_lvl;

  // level update
  always_comb begin
    lvl_new = st.level;
    ev      = EV_NONE;
    if (take) begin
      if (tgt > st.level) begin
        lvl_new = tgt;
        ev      = EV_ESCALATE;
      end else if ((tgt < st.level) && can_step) begin
        lvl_new = lvl_t'(st.level - 2'd1);
        ev      = EV_STEP_DOWN;
      end
    end
  end

  // next state
  always_comb begin
    st_nxt       = st;
    st_nxt.level = lvl_new;
    if (take) begin
      st_nxt.last_time      = item.now_ms;
      st_nxt.sampled_before = 1'b1;
      st_nxt.held_free      = item.free_bytes;
      st_nxt.held_min_free  = item.min_free_bytes;
      st_nxt.held_largest   = item.largest_block_bytes;
    end
  end

  // result item
  always_comb begin
    result.pressure_level  = lvl_new;
    result.sampled         = take;
    result.event_code      = ev;
    result.stored_free     = st_nxt.held_free;
    result.stored_min_free = st_nxt.held_min_free;
    result.stored_largest  = st_nxt.held_largest;
    case (lvl_new)
      LVL_CRITICAL:  result.scale_factor = SCALE_CRIT;
      LVL_EMERGENCY: result.scale_factor = SCALE_EMER;
      default:       result.scale_factor = SCALE_BASE;
    endcase
  end

endmodule

// ===== rtl/memory_pressure_level_monitor.sv =====
// ---------------------------------------------------------------------------
// memory_pressure_level_monitor
// four-level memory pressure monitor with hysteresis on the way down
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries a timestamp and three
//   free-memory readings; an item is taken when in_valid is high and in_stall
//   is low. Each input item yields exactly one result item on out_valid /
//   out_stall / out_data: pressure level, period scale, sampled flag, event
//   code and the last accepted readings.
//   An item passes one input register, then the decision logic into the
//   result register. Throughput is one item per cycle while out_stall is
//   low, set by the single state update per item inside the decision stage.
//   While the receiver stalls, the result register holds and one more item
//   can wait in the input register; in_stall rises only when both are full.
//   Reset (rst_n low, synchronous) loads the threshold reset values, clears
//   the level to normal, the held readings to zero and empties both stages.
//   Configuration writes over the cfg_ bus take effect on the next edge and
//   are meant for when the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module memory_pressure_level_monitor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mplm_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mplm_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mplm_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [mplm_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [mplm_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import mplm_pkg::*;
  `include "memory_pressure_level_monitor_macros.svh"

  cfg_t       cfg;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_item_r;
  mon_state_t st_r;
  mon_state_t st_nxt;
  out_item_t  result;
  logic       in_take;
  logic       s2_adv;

  // configuration registers
  mplm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // decision logic between input register and result register
  mplm_eval u_eval (
    .cfg    (cfg),
    .item   (s1_item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .result (result)
  );

  // handshake
  assign s2_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // valid flags and monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{last_time: '0, sampled_before: 1'b0, level: LVL_NORMAL,
                       held_free: '0, held_min_free: '0, held_largest: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s2_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s2_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // checks on the decision stage
  `MPLM_ASSERT_IMPL(a_event_needs_sample, out_valid_r && (out_item_r.event_code != EV_NONE), out_item_r.sampled, "level event on an item that was not sampled")
  `MPLM_ASSERT_NEXT(a_level_tracks_result, s2_adv, st_r.level == lvl_t'(out_item_r.pressure_level), "level state differs from last result")
  `MPLM_ASSERT_IMPL(a_scale_matches, out_valid_r, (out_item_r.scale_factor == SCALE_EMER) == (out_item_r.pressure_level == LVL_EMERGENCY), "scale does not match level")
  `MPLM_ASSERT_IMPL(a_stall_only_full, in_stall, s1_valid_r && out_valid_r, "input stalled with a free stage")
  `MPLM_ASSERT_NEXT(a_sampled_sticks, st_r.sampled_before, st_r.sampled_before, "sampled flag cleared without reset")

endmodule

// ===== tb/memory_pressure_level_monitor_tb.sv =====
// ---------------------------------------------------------------------------
// memory_pressure_level_monitor_tb
// Drives timestamped free-memory readings into the pressure monitor and
// checks every result against a cycle-free predictor of the level logic.
// A directed table covers reset, the sample-period edges, signed time wrap,
// the hysteresis steps and odd register settings; random blocks follow,
// each under a fresh register setting, with an idling pattern per third.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module memory_pressure_level_monitor_tb;
  import mplm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_BLOCKS    = 12;
  localparam int BLOCK_ITEMS    = 58;

  // one row of the directed table: a register write or an item
  typedef struct {
    bit          is_cfg;
    reg_idx_t    ridx;
    logic [31:0] rval;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr = '0;
  logic [DATA_W-1:0]     cfg_pwdata = '0;
  logic [DATA_W-1:0]     cfg_prdata;
  logic                  cfg_pready;

  // register copy and monitor state as the predictor sees them
  cfg_t                  model_cfg;
  logic [TIME_W-1:0]     p_last_ms;
  logic                  p_have_sample;
  lvl_t                  p_level;
  logic [BYTE_COUNT_BITS-1:0] p_free;
  logic [BYTE_COUNT_BITS-1:0] p_min_free;
  logic [BYTE_COUNT_BITS-1:0] p_largest;

  out_item_t             pending_results[$];
  out_item_t             next_result;
  stim_row_t             stim_tab[$];
  bit                    row_typed = 1'b0;
  out_item_t             row_want = '0;

  int                    send_idle_pct = 37;
  int                    recv_idle_pct = 77;
  int                    idle_cycles = 0;
  int                    err_count = 0;
  int                    n_items = 0;
  int                    n_checked = 0;
  int                    n_writes = 0;
  int                    n_rise = 0;
  int                    n_fall = 0;
  int                    n_skipped = 0;

  memory_pressure_level_monitor DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // entry threshold of a level, zero for normal
  function automatic logic [BYTE_COUNT_BITS-1:0] entry_of(lvl_t lvl);
    case (lvl)
      LVL_EMERGENCY: return model_cfg.emergency_threshold;
      LVL_CRITICAL:  return model_cfg.critical_threshold;
      LVL_WARN:      return model_cfg.warn_threshold;
      default:       return '0;
    endcase
  endfunction

  // level update for one item, advances the predicted state
  function automatic out_item_t predict_pressure(in_item_t it);
    out_item_t                res;
    logic [TIME_W-1:0]        elapsed;
    logic                     take;
    lvl_t                     goal;
    logic [BYTE_COUNT_BITS:0] release_at;
    ev_t                      ev;
    take = 1'b1;
    ev = EV_NONE;
    // signed wrapping compare against the sample period
    if (p_have_sample) begin
      elapsed = it.now_ms - p_last_ms;
      if (elapsed[TIME_W-1] || elapsed < TIME_W'(model_cfg.sample_period_ms)) take = 1'b0;
    end
    if (take) begin
      p_last_ms = it.now_ms;
      p_have_sample = 1'b1;
      p_free = it.free_bytes;
      p_min_free = it.min_free_bytes;
      p_largest = it.largest_block_bytes;
      // emergency tested first, so misordered thresholds resolve upward
      if (p_free < model_cfg.emergency_threshold) goal = LVL_EMERGENCY;
      else if (p_free < model_cfg.critical_threshold) goal = LVL_CRITICAL;
      else if (p_free < model_cfg.warn_threshold) goal = LVL_WARN;
      else goal = LVL_NORMAL;
      // step-down point carries one extra bit so it cannot wrap
      release_at = {1'b0, entry_of(p_level)} + {1'b0, model_cfg.hysteresis_bytes};
      if (goal > p_level) begin
        p_level = goal;
        ev = EV_ESCALATE;
      end else if (goal < p_level && {1'b0, p_free} > release_at) begin
        p_level = lvl_t'(p_level - 2'd1);
        ev = EV_STEP_DOWN;
      end
    end
    res.pressure_level = p_level;
    case (p_level)
      LVL_CRITICAL:  res.scale_factor = SCALE_CRIT;
      LVL_EMERGENCY: res.scale_factor = SCALE_EMER;
      default:       res.scale_factor = SCALE_BASE;
    endcase
    res.sampled = take;
    res.event_code = ev;
    res.stored_free = p_free;
    res.stored_min_free = p_min_free;
    res.stored_largest = p_largest;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH result %0d %s: got %0h expected %0h",
             $realtime, n_checked, what, got, want);
    err_count++;
  endtask

  task automatic compare_result(out_item_t got, out_item_t want);
    if (got.pressure_level !== want.pressure_level)
      report_mismatch("pressure_level", 32'(got.pressure_level), 32'(want.pressure_level));
    if (got.scale_factor !== want.scale_factor)
      report_mismatch("scale_factor", 32'(got.scale_factor), 32'(want.scale_factor));
    if (got.sampled !== want.sampled)
      report_mismatch("sampled", 32'(got.sampled), 32'(want.sampled));
    if (got.event_code !== want.event_code)
      report_mismatch("event_code", 32'(got.event_code), 32'(want.event_code));
    if (got.stored_free !== want.stored_free)
      report_mismatch("stored_free", 32'(got.stored_free), 32'(want.stored_free));
    if (got.stored_min_free !== want.stored_min_free)
      report_mismatch("stored_min_free", 32'(got.stored_min_free), 32'(want.stored_min_free));
    if (got.stored_largest !== want.stored_largest)
      report_mismatch("stored_largest", 32'(got.stored_largest), 32'(want.stored_largest));
  endtask

  // scoreboard: predict on accepted items, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      next_result = predict_pressure(in_data);
      if (row_typed) next_result = row_want;
      pending_results.push_back(next_result);
      n_items++;
      if (next_result.event_code == EV_ESCALATE) n_rise++;
      if (next_result.event_code == EV_STEP_DOWN) n_fall++;
      if (!next_result.sampled) n_skipped++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0)
        report_mismatch("result with no item pending", 32'(out_data.pressure_level), 32'd0);
      else
        compare_result(out_data, pending_results.pop_front());
      n_checked++;
    end
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles = 0;
    else idle_cycles++;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles with no handshake at all
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("[%0t] watchdog expired, %0d results outstanding",
             $realtime, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // present one item, wait for it to be taken; called and returns at negedge
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop sending and wait until every expected result is in
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // two-phase bus write, only with the block idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    drain_results();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'({idx, 2'b00});
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_WARN:   model_cfg.warn_threshold = val[BYTE_COUNT_BITS-1:0];
      REG_CRIT:   model_cfg.critical_threshold = val[BYTE_COUNT_BITS-1:0];
      REG_EMER:   model_cfg.emergency_threshold = val[BYTE_COUNT_BITS-1:0];
      REG_HYST:   model_cfg.hysteresis_bytes = val[BYTE_COUNT_BITS-1:0];
      REG_PERIOD: model_cfg.sample_period_ms = val[PERIOD_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // full register setting for a random block; upper bus bits carry junk
  task automatic apply_config(int mode);
    logic [23:0] emer;
    logic [23:0] crit;
    logic [23:0] warn;
    logic [23:0] hyst;
    logic [15:0] period;
    case (mode)
      0: begin
        // ordered thresholds in a realistic range
        emer = 24'($urandom_range(16'h4000));
        crit = emer + 24'($urandom_range(16'h4000));
        warn = crit + 24'($urandom_range(16'h8000));
        hyst = 24'($urandom_range(16'h2000));
        period = 16'($urandom_range(2000, 1));
      end
      1: begin
        // every threshold at the top, no hysteresis, shortest period
        emer = 24'hFFFFFF;
        crit = 24'hFFFFFF;
        warn = 24'hFFFFFF;
        hyst = 24'h0;
        period = 16'd1;
      end
      2: begin
        // thresholds at zero, widest hysteresis, longest period
        emer = 24'h0;
        crit = 24'h0;
        warn = 24'h0;
        hyst = 24'hFFFFFF;
        period = 16'hFFFF;
      end
      default: begin
        // anything goes, misordered thresholds and zero period included
        emer = 24'($urandom);
        crit = 24'($urandom);
        warn = 24'($urandom);
        hyst = ($urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(16'hFFFF));
        period = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
      end
    endcase
    write_reg(REG_WARN, {8'($urandom), warn});
    write_reg(REG_CRIT, {8'($urandom), crit});
    write_reg(REG_EMER, {8'($urandom), emer});
    write_reg(REG_HYST, {8'($urandom), hyst});
    write_reg(REG_PERIOD, {16'($urandom), period});
  endtask

  // random item aimed at the period edge and the level boundaries
  function automatic in_item_t next_random_item();
    in_item_t                   it;
    int unsigned                pick;
    logic [TIME_W-1:0]          advance;
    logic [BYTE_COUNT_BITS-1:0] base;
    pick = $urandom_range(99);
    if (pick < 45) advance = TIME_W'(model_cfg.sample_period_ms) + $urandom_range(50);
    else if (pick < 60) advance = TIME_W'(model_cfg.sample_period_ms) - 1 + $urandom_range(2);
    else if (pick < 75) advance = $urandom_range(model_cfg.sample_period_ms);
    else if (pick < 85) advance = 32'd0 - $urandom_range(2000, 1);
    else if (pick < 93) advance = 32'h7FFF_FFFE + $urandom_range(3);
    else advance = $urandom;
    it.now_ms = p_last_ms + advance;
    case ($urandom_range(3))
      0: base = model_cfg.warn_threshold;
      1: base = model_cfg.critical_threshold;
      2: base = model_cfg.emergency_threshold;
      default: base = entry_of(p_level) + model_cfg.hysteresis_bytes;
    endcase
    pick = $urandom_range(99);
    if (pick < 60) it.free_bytes = base + 24'($urandom_range(4)) - 24'd2;
    else if (pick < 80) it.free_bytes = 24'($urandom);
    else if (pick < 90) it.free_bytes = ($urandom_range(1)) ? 24'hFFFFFF : 24'h0;
    else it.free_bytes = 24'($urandom_range(model_cfg.emergency_threshold));
    it.min_free_bytes = 24'($urandom);
    it.largest_block_bytes = 24'($urandom);
    return it;
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_t idx, logic [31:0] val);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.ridx = idx;
    r.rval = val;
    r.item = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [31:0] now, logic [23:0] fr,
                                         logic [23:0] mn, logic [23:0] lg);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.ridx = REG_WARN;
    r.rval = '0;
    r.item.now_ms = now;
    r.item.free_bytes = fr;
    r.item.min_free_bytes = mn;
    r.item.largest_block_bytes = lg;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [31:0] now, logic [23:0] fr,
                                          logic [23:0] mn, logic [23:0] lg,
                                          lvl_t lvl, logic [2:0] sc, logic smp, ev_t ev,
                                          logic [23:0] sf, logic [23:0] smf,
                                          logic [23:0] sl);
    stim_row_t r;
    r = item_row(now, fr, mn, lg);
    r.typed = 1'b1;
    r.want.pressure_level = lvl;
    r.want.scale_factor = sc;
    r.want.sampled = smp;
    r.want.event_code = ev;
    r.want.stored_free = sf;
    r.want.stored_min_free = smf;
    r.want.stored_largest = sl;
    return r;
  endfunction

  initial begin
    int b;
    stim_row_t row;

    model_cfg.warn_threshold = WARN_RESET;
    model_cfg.critical_threshold = CRIT_RESET;
    model_cfg.emergency_threshold = EMER_RESET;
    model_cfg.hysteresis_bytes = HYST_RESET;
    model_cfg.sample_period_ms = PERIOD_RESET;
    p_last_ms = '0;
    p_have_sample = 1'b0;
    p_level = LVL_NORMAL;
    p_free = '0;
    p_min_free = '0;
    p_largest = '0;

    // hold reset, then release it at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first item always taken, then the period boundary from both sides
    stim_tab.push_back(typed_row(32'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, LVL_NORMAL,
                                 SCALE_BASE, 1'b1, EV_NONE, 24'hFFFFFF, 24'hFFFFFF,
                                 24'hFFFFFF));
    stim_tab.push_back(typed_row(32'd999, 24'h0, 24'h0, 24'h0, LVL_NORMAL, SCALE_BASE,
                                 1'b0, EV_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    stim_tab.push_back(typed_row(32'd1000, 24'h0, 24'h0, 24'h0, LVL_EMERGENCY, SCALE_EMER,
                                 1'b1, EV_ESCALATE, 24'h0, 24'h0, 24'h0));
    // time going backwards is too early
    stim_tab.push_back(typed_row(32'd500, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                 LVL_EMERGENCY, SCALE_EMER, 1'b0, EV_NONE,
                                 24'h0, 24'h0, 24'h0));
    // one step down at a time, only once past entry plus hysteresis
    stim_tab.push_back(item_row(32'd2000, 24'd20000, 24'h5A5A5A, 24'hA5A5A5));
    stim_tab.push_back(item_row(32'd3000, 24'd20000, 24'hA5A5A5, 24'h5A5A5A));
    stim_tab.push_back(item_row(32'd4000, 24'd20481, 24'h123456, 24'hABCDEF));
    stim_tab.push_back(item_row(32'd5000, 24'd32768, 24'hFEDCBA, 24'h654321));
    stim_tab.push_back(item_row(32'd6000, 24'd36865, 24'h000001, 24'h800000));
    // jumps straight up
    stim_tab.push_back(item_row(32'd7000, 24'd16383, 24'h7FFFFF, 24'h000000));
    stim_tab.push_back(item_row(32'd8000, 24'd8191, 24'h0F0F0F, 24'hF0F0F0));
    // signed wrap around the half range of the time counter
    stim_tab.push_back(item_row(32'h8000_1F40, 24'd40000, 24'h111111, 24'h222222));
    stim_tab.push_back(item_row(32'h8000_1F3F, 24'd40000, 24'h333333, 24'h444444));
    stim_tab.push_back(item_row(32'hFFFF_FFFF, 24'd50000, 24'hCCCCCC, 24'h333333));
    stim_tab.push_back(item_row(32'd999, 24'd0, 24'h555555, 24'hAAAAAA));
    // zero period takes equal times but still refuses backward time
    stim_tab.push_back(cfg_row(REG_PERIOD, 32'd0));
    stim_tab.push_back(item_row(32'd999, 24'h800000, 24'h0000FF, 24'hFF0000));
    stim_tab.push_back(item_row(32'd0, 24'h000000, 24'hFFFFFF, 24'h000000));
    // misordered thresholds and a step-down point beyond the reading range
    stim_tab.push_back(cfg_row(REG_WARN, 32'd256));
    stim_tab.push_back(cfg_row(REG_CRIT, 32'hFFFFFF));
    stim_tab.push_back(cfg_row(REG_EMER, 32'd4096));
    stim_tab.push_back(cfg_row(REG_HYST, 32'hFFFFFF));
    stim_tab.push_back(item_row(32'd10, 24'hFFFFFE, 24'h00FF00, 24'hFF00FF));
    stim_tab.push_back(item_row(32'd20, 24'hFFFFFF, 24'hABABAB, 24'hBABABA));
    stim_tab.push_back(cfg_row(REG_HYST, 32'd0));
    stim_tab.push_back(item_row(32'd30, 24'hFFFFFF, 24'h010203, 24'h040506));
    stim_tab.push_back(item_row(32'd40, 24'd100, 24'h070809, 24'h0A0B0C));

    foreach (stim_tab[i]) begin
      row = stim_tab[i];
      if (row.is_cfg) write_reg(row.ridx, row.rval);
      else send_item(row.item, row.typed, row.want);
    end

    // random blocks: idling pattern per third, register setting per block
    for (b = 0; b < RAND_BLOCKS; b++) begin
      case (b / (RAND_BLOCKS / 3))
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      apply_config(b % 4);
      repeat (BLOCK_ITEMS) send_item(next_random_item(), 1'b0, '0);
    end

    drain_results();
    $display("covered %0d items, %0d results checked, %0d register writes",
             n_items, n_checked, n_writes);
    $display("level rises %0d, step-downs %0d, readings held back %0d",
             n_rise, n_fall, n_skipped);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== memory_pressure_level_monitor.f =====
+incdir+rtl
rtl/mplm_pkg.sv
rtl/mplm_cfg.sv
rtl/mplm_eval.sv
rtl/memory_pressure_level_monitor.sv
tb/memory_pressure_level_monitor_tb.sv
